>>> rtl/swc_pkg.sv
`timescale 1ns / 1ps
// Package for the separable window convolution block.
// Holds sizes, command codes, register indexes and shared types; no dependencies.
package swc_pkg;
  localparam int unsigned MaxRows = 256;
  localparam int unsigned MaxCols = 256;
  localparam int unsigned MaxHalf = 22;
  localparam int unsigned TapDepth = 2 * MaxHalf + 1;
  localparam int unsigned RowW = $clog2(MaxRows);
  localparam int unsigned ColW = $clog2(MaxCols);
  localparam int unsigned PixDepth = MaxRows * MaxCols;
  localparam int unsigned PixAw = $clog2(PixDepth);
  localparam int unsigned TapAw = $clog2(TapDepth);

  typedef enum logic [1:0] {
    CmdWrPix = 2'd0,
    CmdWrHTap = 2'd1,
    CmdWrVTap = 2'd2,
    CmdFilter = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RegRows = 2'd0,
    RegCols = 2'd1,
    RegHalfH = 2'd2,
    RegHalfV = 2'd3
  } reg_e;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StRowSt = 6'b000010,
    StMac = 6'b000100,
    StRowEnd = 6'b001000,
    StFinal = 6'b010000,
    StOut = 6'b100000
  } state_e;
endpackage

>>> rtl/separable_window_convolution.sv
`timescale 1ns / 1ps
// Top level of the separable window convolution block.
// Depends on swc_pkg and swc_ram (image store and two tap stores).
//
// Usage: input items carry cmd, col, row, tap and value on a valid/ready
// channel. A write or a rejected item shows its result in the cycle after it
// is accepted. A filter query walks the truncated window one pixel product
// per cycle: for each window row a setup step, one step per column plus one
// for the last read to return, and a step to weight the row sum by its
// vertical tap, then a final step. The single multiply-accumulate and the
// one image read port set this rate.
// Each item yields one result item on the output valid/ready channel,
// held in an output register; the next item is accepted only once that
// result is taken, so a stalled receiver simply holds the block.
// Reset restores the size registers (256 by 256, half sizes 3) and
// empties the output register; the stores are undefined until written.
// Configuration writes are taken at any time on their own channel.
module separable_window_convolution (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [7:0]         col_i,
  input  logic [7:0]         row_i,
  input  logic [5:0]         tap_i,
  input  logic signed [15:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] filtered_o,
  output logic               status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [8:0]         cfg_data_i
);
  logic [8:0] rows_q, cols_q;
  logic [4:0] hh_q, hv_q;
  swc_pkg::state_e state_q, state_d;

  // Clamped sizes.
  logic [8:0] m_w, n_w;
  logic [4:0] kh_w, kv_w;
  always_comb begin
    m_w = (rows_q == 9'd0) ? 9'd1 : (rows_q > 9'(swc_pkg::MaxRows)) ? 9'(swc_pkg::MaxRows)
                                                                    : rows_q;
    n_w = (cols_q == 9'd0) ? 9'd1 : (cols_q > 9'(swc_pkg::MaxCols)) ? 9'(swc_pkg::MaxCols)
                                                                    : cols_q;
    kh_w = (hh_q > 5'(swc_pkg::MaxHalf)) ? 5'(swc_pkg::MaxHalf) : hh_q;
    kv_w = (hv_q > 5'(swc_pkg::MaxHalf)) ? 5'(swc_pkg::MaxHalf) : hv_q;
  end

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 9'd256;
      cols_q <= 9'd256;
      hh_q <= 5'd3;
      hv_q <= 5'd3;
    end else if (cfg_valid_i) begin
      unique case (swc_pkg::reg_e'(cfg_index_i))
        swc_pkg::RegRows: rows_q <= cfg_data_i;
        swc_pkg::RegCols: cols_q <= cfg_data_i;
        swc_pkg::RegHalfH: hh_q <= cfg_data_i[4:0];
        swc_pkg::RegHalfV: hv_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  logic in_acc;
  assign in_ready_o = (state_q == swc_pkg::StIdle);
  assign in_acc = in_valid_i && in_ready_o;

  logic pos_ok, tap_ok_h, tap_ok_v;
  assign pos_ok = ({1'b0, col_i} < n_w) && ({1'b0, row_i} < m_w);
  assign tap_ok_h = {1'b0, tap_i} <= {1'b0, kh_w, 1'b0};
  assign tap_ok_v = {1'b0, tap_i} <= {1'b0, kv_w, 1'b0};

  // Window walk registers; positions are signed 10 bit.
  logic signed [9:0] x_q, y_q, lox_q, hix_q, hiy_q, j_q, i_q, j_d, i_d;
  logic signed [9:0] kh_s, kv_s, n_s, m_s;
  assign kh_s = 10'(kh_w);
  assign kv_s = 10'(kv_w);
  assign n_s = 10'(n_w);
  assign m_s = 10'(m_w);

  logic signed [47:0] acc_q, acc_d;
  logic signed [63:0] tot_q, tot_d;
  logic rd_q, rd_d; // a pixel/tap read is in flight
  logic signed [31:0] res_q, res_d;
  logic st_q, st_d;

  logic pix_we, htap_we, vtap_we;
  logic [swc_pkg::PixAw-1:0] pix_wa, pix_ra;
  logic [swc_pkg::TapAw-1:0] htap_ra, vtap_ra;
  logic signed [15:0] pix_rd, htap_rd, vtap_rd;
  assign pix_we = in_acc && (swc_pkg::cmd_e'(cmd_i) == swc_pkg::CmdWrPix) && pos_ok;
  assign htap_we = in_acc && (swc_pkg::cmd_e'(cmd_i) == swc_pkg::CmdWrHTap) && tap_ok_h;
  assign vtap_we = in_acc && (swc_pkg::cmd_e'(cmd_i) == swc_pkg::CmdWrVTap) && tap_ok_v;
  assign pix_wa = {row_i, col_i};
  logic signed [9:0] r_w, c_w, hti_w, vti_w;
  assign r_w = y_q + i_q;
  assign c_w = x_q + j_q;
  assign hti_w = kh_s + j_q;
  assign vti_w = kv_s + i_q;
  assign pix_ra = {r_w[swc_pkg::RowW-1:0], c_w[swc_pkg::ColW-1:0]};
  assign htap_ra = hti_w[swc_pkg::TapAw-1:0];
  assign vtap_ra = vti_w[swc_pkg::TapAw-1:0];

  swc_ram #(.Width(16), .Depth(swc_pkg::PixDepth)) u_img (
    .clk_i, .we_i(pix_we), .waddr_i(pix_wa), .wdata_i(value_i),
    .raddr_i(pix_ra), .rdata_o(pix_rd));
  swc_ram #(.Width(16), .Depth(swc_pkg::TapDepth)) u_htap (
    .clk_i, .we_i(htap_we), .waddr_i(tap_i[swc_pkg::TapAw-1:0]), .wdata_i(value_i),
    .raddr_i(htap_ra), .rdata_o(htap_rd));
  swc_ram #(.Width(16), .Depth(swc_pkg::TapDepth)) u_vtap (
    .clk_i, .we_i(vtap_we), .waddr_i(tap_i[swc_pkg::TapAw-1:0]), .wdata_i(value_i),
    .raddr_i(vtap_ra), .rdata_o(vtap_rd));

  logic signed [31:0] prod_w;
  assign prod_w = pix_rd * htap_rd;
  logic signed [32:0] accsh_w; // floor shift of the row sum
  assign accsh_w = 33'(acc_q >>> 15);
  logic signed [48:0] wprod_w;
  assign wprod_w = accsh_w * vtap_rd;
  logic signed [48:0] totsh_w;
  assign totsh_w = 49'(tot_q >>> 15);

  always_comb begin
    state_d = state_q;
    j_d = j_q;
    i_d = i_q;
    acc_d = acc_q;
    tot_d = tot_q;
    rd_d = 1'b0;
    res_d = res_q;
    st_d = st_q;
    unique case (state_q)
      swc_pkg::StIdle: begin
        if (in_acc) begin
          res_d = '0;
          tot_d = '0;
          j_d = 10'sd0;
          i_d = (10'(row_i) >= kv_s) ? -kv_s : -10'(row_i);
          unique case (swc_pkg::cmd_e'(cmd_i))
            swc_pkg::CmdWrPix: begin
              st_d = !pos_ok;
              state_d = swc_pkg::StOut;
            end
            swc_pkg::CmdWrHTap: begin
              st_d = !tap_ok_h;
              state_d = swc_pkg::StOut;
            end
            swc_pkg::CmdWrVTap: begin
              st_d = !tap_ok_v;
              state_d = swc_pkg::StOut;
            end
            default: begin
              st_d = !pos_ok;
              state_d = pos_ok ? swc_pkg::StRowSt : swc_pkg::StOut;
            end
          endcase
        end
      end
      swc_pkg::StRowSt: begin
        acc_d = '0;
        j_d = lox_q;
        state_d = swc_pkg::StMac;
      end
      swc_pkg::StMac: begin
        if (rd_q) acc_d = acc_q + 48'(prod_w);
        if (j_q > hix_q) begin
          state_d = swc_pkg::StRowEnd;
          j_d = 10'sd0;
        end else begin
          rd_d = 1'b1;
          j_d = j_q + 10'sd1;
        end
      end
      swc_pkg::StRowEnd: begin
        // vertical tap read was issued last cycle for row i
        tot_d = tot_q + 64'(wprod_w);
        if (i_q >= hiy_q) state_d = swc_pkg::StFinal;
        else begin
          i_d = i_q + 10'sd1;
          state_d = swc_pkg::StRowSt;
        end
      end
      swc_pkg::StFinal: begin
        if (totsh_w > 49'sh7FFFFFFF) res_d = 32'sh7FFFFFFF;
        else if (totsh_w < -49'sh80000000) res_d = 32'sh80000000;
        else res_d = totsh_w[31:0];
        state_d = swc_pkg::StOut;
      end
      swc_pkg::StOut: begin
        if (out_ready_i) state_d = swc_pkg::StIdle;
      end
      default: state_d = swc_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swc_pkg::StIdle;
      rd_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q <= j_d;
    i_q <= i_d;
    acc_q <= acc_d;
    tot_q <= tot_d;
    res_q <= res_d;
    st_q <= st_d;
    if (in_acc) begin
      x_q <= 10'(col_i);
      y_q <= 10'(row_i);
      lox_q <= (10'(col_i) >= kh_s) ? -kh_s : -10'(col_i);
      hix_q <= (10'(col_i) + kh_s < n_s) ? kh_s : n_s - 10'(col_i) - 10'sd1;
      hiy_q <= (10'(row_i) + kv_s < m_s) ? kv_s : m_s - 10'(row_i) - 10'sd1;
    end
  end

  assign out_valid_o = (state_q == swc_pkg::StOut);
  assign filtered_o = res_q;
  assign status_o = st_q;

  ap_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready during result");
  ap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(filtered_o))
    else $error("result dropped");
  ap_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> filtered_o == 32'sd0) else $error("error with value");
endmodule

>>> rtl/swc_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
module swc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
